### src/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg: shared constants and types of the refraction direction pipeline
// Fixed-point formats, intermediate widths and the per-stage work record.
// ----------------------------------------------------------------------------
package rfd_pkg;

   // Fixed-point format: 16-bit words with FRAC_BITS fraction bits
   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 14;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int HALF      = 1 << (FRAC_BITS - 1);

   // Intermediate widths
   localparam int PROD_W    = 2 * DATA_W;               // d*n, eta*eta
   localparam int ED_W      = 2 * DATA_W + 1;           // eta*d (eta zero-extended)
   localparam int DOT_W     = 2 * DATA_W + 2;           // sum of three products
   localparam int COS_W     = DOT_W - FRAC_BITS;        // cos_i
   localparam int ETA2_W    = 2 * DATA_W + 1 - FRAC_BITS;
   localparam int SQ_W      = 2 * COS_W;                // cos_i squared
   localparam int SQR_W     = SQ_W + 1;
   localparam int EC_PROD_W = DATA_W + 1 + COS_W;       // eta*cos_i
   localparam int EC_W      = EC_PROD_W - FRAC_BITS;
   localparam int S_W       = FRAC_BITS + 1;            // sin2_i, 1 - sin2_t
   localparam int S2T_P_W   = ETA2_W + S_W;             // eta2*sin2_i
   localparam int S2T_W     = S2T_P_W + 1 - FRAC_BITS;  // sin2_t
   localparam int ROOT_W    = FRAC_BITS + 1;            // cos_t
   localparam int RAD_W     = 2 * ROOT_W;               // square root operand
   localparam int REM_W     = ROOT_W + 3;               // square root remainder
   localparam int COEF_W    = EC_W + 1;
   localparam int CN_W      = COEF_W + DATA_W;
   localparam int ACC_W     = CN_W + 1;

   // Square root: result bits resolved per pipeline stage
   localparam int SQRT_STEPS  = 3;
   localparam int SQRT_STAGES = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;

   // Saturation bounds of an output component
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Work record that travels down the pipeline
   typedef struct packed {
      logic [2:0][DATA_W-1:0] norm;
      logic [DATA_W-1:0]      eta;
      logic [2:0][PROD_W-1:0] dn;
      logic [2:0][ED_W-1:0]   ed;
      logic [PROD_W-1:0]      eta_sq;
      logic [COS_W-1:0]       cosi;
      logic [ETA2_W-1:0]      eta2;
      logic [SQ_W-1:0]        cos_sq;
      logic [EC_PROD_W-1:0]   eta_cos;
      logic [S_W-1:0]         sin2i;
      logic [EC_W-1:0]        ec;
      logic [S2T_P_W-1:0]     s2t_prod;
      logic                   tir;
      logic [RAD_W-1:0]       rad;
      logic [REM_W-1:0]       rem;
      logic [ROOT_W-1:0]      root;
      logic [COEF_W-1:0]      coef;
      logic [2:0][CN_W-1:0]   cn;
   } work_type;

endpackage

### src/rfd_req_if.sv
// ----------------------------------------------------------------------------
// rfd_req_if: request channel of the refraction direction block
// Valid/ready channel carrying the incident direction, normal and index ratio.
// ----------------------------------------------------------------------------
interface rfd_req_if;

   logic                              valid;
   logic                              ready;
   logic signed [rfd_pkg::DATA_W-1:0] dir_x;
   logic signed [rfd_pkg::DATA_W-1:0] dir_y;
   logic signed [rfd_pkg::DATA_W-1:0] dir_z;
   logic signed [rfd_pkg::DATA_W-1:0] norm_x;
   logic signed [rfd_pkg::DATA_W-1:0] norm_y;
   logic signed [rfd_pkg::DATA_W-1:0] norm_z;
   logic        [rfd_pkg::DATA_W-1:0] index_ratio;

   modport source (
      output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio,
      input  ready
   );

   modport sink (
      input  valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio,
      output ready
   );

endinterface

### src/rfd_rsp_if.sv
// ----------------------------------------------------------------------------
// rfd_rsp_if: response channel of the refraction direction block
// Valid/ready channel carrying the transmitted direction and refraction flag.
// ----------------------------------------------------------------------------
interface rfd_rsp_if;

   logic                              valid;
   logic                              ready;
   logic signed [rfd_pkg::DATA_W-1:0] trans_x;
   logic signed [rfd_pkg::DATA_W-1:0] trans_y;
   logic signed [rfd_pkg::DATA_W-1:0] trans_z;
   logic                              refracted;

   modport source (
      output valid, trans_x, trans_y, trans_z, refracted,
      input  ready
   );

   modport sink (
      input  valid, trans_x, trans_y, trans_z, refracted,
      output ready
   );

endinterface

### src/refraction_direction.sv
// ----------------------------------------------------------------------------
// refraction_direction: Snell refraction of a direction about a normal
// Fixed-point pipeline: dot product, sin^2 terms, digit-recurrence square
// root, and the transmitted vector t = -eta*d + (eta*cos_i - cos_t)*n.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one ray per transaction: direction and normal in signed
//   Q2.14 and the index ratio in unsigned Q2.14. rsp_chan returns one
//   transaction per request, in order: the saturated transmitted direction
//   and the refracted flag (low with zero components on total internal
//   reflection).
//   From request accept to response valid a transaction passes six
//   arithmetic stages, five square-root stages resolving three root bits
//   each, then coefficient, multiply and output stages.
//   Throughput is one transaction per cycle while the receiver takes responses;
//   every stage holds its own valid bit, so bubbles collapse and a new
//   request is taken whenever the first stage is empty or moving.
//   When the receiver stalls, the output register holds its transaction and
//   the stages behind it fill up; req_chan.ready drops only once the first
//   stage is full and blocked.
//   Reset (synchronous, active high) empties the pipeline; no transaction
//   is in flight afterwards.
// ----------------------------------------------------------------------------
module refraction_direction (
   input logic       clock,
   input logic       reset,
   rfd_req_if.sink   req_chan,
   rfd_rsp_if.source rsp_chan
);

   // Stage indexes
   localparam int ST_PROD    = 0;
   localparam int ST_DOT     = 1;
   localparam int ST_MUL1    = 2;
   localparam int ST_SIN2I   = 3;
   localparam int ST_MUL2    = 4;
   localparam int ST_SIN2T   = 5;
   localparam int ST_SQRT0   = 6;
   localparam int ST_COEF    = ST_SQRT0 + rfd_pkg::SQRT_STAGES;
   localparam int ST_CN      = ST_COEF + 1;
   localparam int ST_OUT     = ST_CN + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   logic [NUM_STAGES-1:0]       vld_ff;
   logic [NUM_STAGES-1:0]       vld_in;
   logic [NUM_STAGES-1:0]       adv;
   rfd_pkg::work_type           work_ff [ST_OUT];
   rfd_pkg::work_type           work_in [ST_OUT];
   logic [2:0][rfd_pkg::DATA_W-1:0] trans_ff;
   logic [2:0][rfd_pkg::DATA_W-1:0] trans_in;
   logic                        refr_ff;
   logic                        refr_in;

   // Advance chain: a stage loads when it is empty or its successor loads
   always_comb begin
      adv[ST_OUT] = !vld_ff[ST_OUT] || rsp_chan.ready;
      for (int i = ST_OUT - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i + 1];
      end
   end

   assign req_chan.ready = adv[ST_PROD];

   // Valid bits travel with the data
   always_comb begin
      vld_in[ST_PROD] = req_chan.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = vld_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Stage 0: products d*n, eta*d, eta*eta
   always_comb begin
      rfd_pkg::work_type w;
      logic signed [rfd_pkg::DATA_W-1:0] dir_s  [3];
      logic signed [rfd_pkg::DATA_W:0]   eta_s;
      w        = '0;
      dir_s[0] = req_chan.dir_x;
      dir_s[1] = req_chan.dir_y;
      dir_s[2] = req_chan.dir_z;
      w.norm[0] = req_chan.norm_x;
      w.norm[1] = req_chan.norm_y;
      w.norm[2] = req_chan.norm_z;
      w.eta     = req_chan.index_ratio;
      eta_s     = $signed({1'b0, req_chan.index_ratio});
      for (int k = 0; k < 3; k++) begin
         w.dn[k] = dir_s[k] * $signed(w.norm[k]);
         w.ed[k] = eta_s * dir_s[k];
      end
      w.eta_sq = w.eta * w.eta;
      work_in[ST_PROD] = w;
   end

   // Stage 1: cos_i = rnd(d.n), eta2 = rnd(eta^2)
   always_comb begin
      rfd_pkg::work_type w;
      logic signed [rfd_pkg::DOT_W-1:0] dot_sum;
      logic signed [rfd_pkg::DOT_W-1:0] dot_rnd;
      logic signed [rfd_pkg::DOT_W-1:0] dot_sh;
      logic [rfd_pkg::PROD_W:0]         eta_rnd;
      w       = work_ff[ST_PROD];
      dot_sum = rfd_pkg::DOT_W'($signed(w.dn[0])) + rfd_pkg::DOT_W'($signed(w.dn[1]))
              + rfd_pkg::DOT_W'($signed(w.dn[2]));
      dot_rnd = dot_sum + rfd_pkg::DOT_W'(rfd_pkg::HALF);
      dot_sh  = dot_rnd >>> rfd_pkg::FRAC_BITS;
      w.cosi  = dot_sh[rfd_pkg::COS_W-1:0];
      eta_rnd = {1'b0, w.eta_sq} + (rfd_pkg::PROD_W + 1)'(rfd_pkg::HALF);
      w.eta2  = eta_rnd[rfd_pkg::PROD_W:rfd_pkg::FRAC_BITS];
      work_in[ST_DOT] = w;
   end

   // Stage 2: cos_i^2 and eta*cos_i
   always_comb begin
      rfd_pkg::work_type w;
      w         = work_ff[ST_DOT];
      w.cos_sq  = $signed(w.cosi) * $signed(w.cosi);
      w.eta_cos = $signed({1'b0, w.eta}) * $signed(w.cosi);
      work_in[ST_MUL1] = w;
   end

   // Stage 3: sin2_i = max(0, ONE - rnd(cos_i^2)), ec = rnd(eta*cos_i)
   always_comb begin
      rfd_pkg::work_type w;
      logic signed [rfd_pkg::SQR_W-1:0]     sq_rnd;
      logic signed [rfd_pkg::SQR_W-1:0]     sq_sh;
      logic signed [rfd_pkg::SQR_W-1:0]     diff;
      logic signed [rfd_pkg::EC_PROD_W:0]   ec_rnd;
      logic signed [rfd_pkg::EC_PROD_W:0]   ec_sh;
      w      = work_ff[ST_MUL1];
      sq_rnd = rfd_pkg::SQR_W'($signed(w.cos_sq)) + rfd_pkg::SQR_W'(rfd_pkg::HALF);
      sq_sh  = sq_rnd >>> rfd_pkg::FRAC_BITS;
      diff   = rfd_pkg::SQR_W'(rfd_pkg::ONE) - sq_sh;
      if (diff[rfd_pkg::SQR_W-1]) begin
         w.sin2i = '0;
      end else begin
         w.sin2i = diff[rfd_pkg::S_W-1:0];
      end
      ec_rnd = (rfd_pkg::EC_PROD_W + 1)'($signed(w.eta_cos))
             + (rfd_pkg::EC_PROD_W + 1)'(rfd_pkg::HALF);
      ec_sh  = ec_rnd >>> rfd_pkg::FRAC_BITS;
      w.ec   = ec_sh[rfd_pkg::EC_W-1:0];
      work_in[ST_SIN2I] = w;
   end

   // Stage 4: eta2 * sin2_i
   always_comb begin
      rfd_pkg::work_type w;
      w          = work_ff[ST_SIN2I];
      w.s2t_prod = w.eta2 * w.sin2i;
      work_in[ST_MUL2] = w;
   end

   // Stage 5: sin2_t, total internal reflection test, root operand
   always_comb begin
      rfd_pkg::work_type w;
      logic [rfd_pkg::S2T_P_W:0]  s2t_rnd;
      logic [rfd_pkg::S2T_W-1:0]  sin2t;
      logic [rfd_pkg::S_W-1:0]    rad_base;
      w        = work_ff[ST_MUL2];
      s2t_rnd  = {1'b0, w.s2t_prod} + (rfd_pkg::S2T_P_W + 1)'(rfd_pkg::HALF);
      sin2t    = s2t_rnd[rfd_pkg::S2T_P_W:rfd_pkg::FRAC_BITS];
      w.tir    = (sin2t >= rfd_pkg::S2T_W'(rfd_pkg::ONE));
      rad_base = rfd_pkg::S_W'(rfd_pkg::ONE) - sin2t[rfd_pkg::S_W-1:0];
      w.rad    = rfd_pkg::RAD_W'(rad_base) << rfd_pkg::FRAC_BITS;
      w.rem    = '0;
      w.root   = '0;
      work_in[ST_SIN2T] = w;
   end

   // Square root stages: digit recurrence, SQRT_STEPS root bits per stage
   for (genvar g = 0; g < rfd_pkg::SQRT_STAGES; g++) begin : g_sqrt
      always_comb begin
         rfd_pkg::work_type w;
         logic [rfd_pkg::REM_W-1:0] rem_t;
         logic [rfd_pkg::REM_W-1:0] trial;
         w = work_ff[ST_SQRT0 + g - 1];
         for (int s = 0; s < rfd_pkg::SQRT_STEPS; s++) begin
            if (g * rfd_pkg::SQRT_STEPS + s < rfd_pkg::ROOT_W) begin
               rem_t = {w.rem[rfd_pkg::REM_W-3:0], w.rad[rfd_pkg::RAD_W-1 -: 2]};
               w.rad = w.rad << 2;
               trial = rfd_pkg::REM_W'({w.root, 2'b01});
               if (rem_t >= trial) begin
                  w.rem  = rem_t - trial;
                  w.root = {w.root[rfd_pkg::ROOT_W-2:0], 1'b1};
               end else begin
                  w.rem  = rem_t;
                  w.root = {w.root[rfd_pkg::ROOT_W-2:0], 1'b0};
               end
            end
         end
         work_in[ST_SQRT0 + g] = w;
      end
   end

   // Coefficient: rnd(eta*cos_i) - cos_t
   always_comb begin
      rfd_pkg::work_type w;
      w      = work_ff[ST_COEF - 1];
      w.coef = rfd_pkg::COEF_W'($signed(w.ec))
             - rfd_pkg::COEF_W'($signed({1'b0, w.root}));
      work_in[ST_COEF] = w;
   end

   // Scale the normal by the coefficient
   always_comb begin
      rfd_pkg::work_type w;
      w = work_ff[ST_COEF];
      for (int k = 0; k < 3; k++) begin
         w.cn[k] = $signed(w.coef) * $signed(w.norm[k]);
      end
      work_in[ST_CN] = w;
   end

   // Advance the work records
   always_ff @(posedge clock) begin
      for (int i = 0; i < ST_OUT; i++) begin
         if (adv[i]) begin
            work_ff[i] <= work_in[i];
         end
      end
   end

   // Output stage: combine, round, saturate; zero on total internal reflection
   always_comb begin
      logic signed [rfd_pkg::ACC_W-1:0]     acc;
      logic signed [rfd_pkg::ACC_W-1:0]     acc_rnd;
      logic signed [rfd_pkg::ACC_W-1:0]     acc_sh;
      logic [rfd_pkg::ACC_W-rfd_pkg::DATA_W:0] hi;
      for (int k = 0; k < 3; k++) begin
         acc     = rfd_pkg::ACC_W'($signed(work_ff[ST_CN].cn[k]))
                 - rfd_pkg::ACC_W'($signed(work_ff[ST_CN].ed[k]));
         acc_rnd = acc + rfd_pkg::ACC_W'(rfd_pkg::HALF);
         acc_sh  = acc_rnd >>> rfd_pkg::FRAC_BITS;
         hi      = acc_sh[rfd_pkg::ACC_W-1:rfd_pkg::DATA_W-1];
         if (work_ff[ST_CN].tir) begin
            trans_in[k] = '0;
         end else if (&hi || ~|hi) begin
            trans_in[k] = acc_sh[rfd_pkg::DATA_W-1:0];
         end else if (acc_sh[rfd_pkg::ACC_W-1]) begin
            trans_in[k] = rfd_pkg::SAT_MIN;
         end else begin
            trans_in[k] = rfd_pkg::SAT_MAX;
         end
      end
      refr_in = !work_ff[ST_CN].tir;
   end

   // Hold the output transaction until taken
   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         trans_ff <= trans_in;
         refr_ff  <= refr_in;
      end
   end

   assign rsp_chan.valid     = vld_ff[ST_OUT];
   assign rsp_chan.trans_x   = trans_ff[0];
   assign rsp_chan.trans_y   = trans_ff[1];
   assign rsp_chan.trans_z   = trans_ff[2];
   assign rsp_chan.refracted = refr_ff;

   // An accepted request occupies the first stage in the next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[ST_PROD])
      else $error("accepted request did not enter the first stage");

   // An empty first stage always takes a request
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[ST_PROD] |-> req_chan.ready)
      else $error("request refused while first stage empty");

   // A blocked stage keeps its transaction
   a_blocked_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_CN] && !adv[ST_OUT] |=> vld_ff[ST_CN])
      else $error("blocked stage dropped its transaction");

   // Total internal reflection gives zero components
   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.refracted |->
         rsp_chan.trans_x == '0 && rsp_chan.trans_y == '0 && rsp_chan.trans_z == '0)
      else $error("nonzero direction on total internal reflection");

endmodule
